@@ rtl/core/nhs_pkg.sv @@
// ----------------------------------------------------------------------------
// nhs_pkg
// shared widths, types, constants and helpers of the neo-hookean stress block
// ----------------------------------------------------------------------------
package nhs_pkg;

  // field widths
  localparam int F_W     = 24;   // deformation gradient entry, q4.20
  localparam int P_W     = 48;   // stress and energy, q32.16
  localparam int CFG_W   = 32;   // configuration data
  localparam int IDX_W   = 8;    // configuration register index

  // internal widths
  localparam int FF_W    = 48;   // product of two entries
  localparam int C_W     = 49;   // cofactor, q.40
  localparam int TR_W    = 52;   // sum of squares minus three, q.40
  localparam int MUF_W   = 57;   // mu times entry, q.36
  localparam int PP_W    = 80;   // partial product
  localparam int W_W     = 120;  // wide accumulator
  localparam int DQ_W    = 44;   // j minus gamma, q.30
  localparam int SQ_W    = 56;   // summed modulus times d, q.24
  localparam int E_W     = 56;   // d squared, q.30
  localparam int DQ_SPL  = 22;   // low part of d in split products
  localparam int SQ_SPL  = 28;   // low part of s in split products
  localparam int E_SPL   = 28;   // low part of d squared in split products
  localparam int RND_W   = 64;   // rounded value before saturation
  localparam int CNT_W   = 5;    // divider step counter
  localparam int LH_W    = 33;   // summed modulus, q17.16
  localparam int GAM_W   = 32;   // gamma, q2.30

  // register indexes
  localparam logic [IDX_W-1:0] REG_SHEAR = 8'd0;
  localparam logic [IDX_W-1:0] REG_BULK  = 8'd1;

  // reset values
  localparam logic [CFG_W-1:0] MU_RST    = 32'd65536;
  localparam logic [CFG_W-1:0] LAM_RST   = 32'd65536;
  localparam logic [LH_W-1:0]  LH_RST    = 33'd131072;
  localparam logic [GAM_W-1:0] GAM_RST   = 32'h6000_0000;  // 1.5
  localparam logic [GAM_W-1:0] GAM_ONE   = 32'h4000_0000;  // 1.0
  localparam logic [CNT_W-1:0] DIV_STEPS = 5'd30;

  // cofactor k = f[A]*f[B] - f[D]*f[E]
  localparam int COF_A [9] = '{4, 6, 3, 7, 0, 6, 1, 3, 0};
  localparam int COF_B [9] = '{8, 5, 7, 2, 8, 1, 5, 2, 4};
  localparam int COF_D [9] = '{7, 3, 6, 1, 6, 0, 4, 0, 3};
  localparam int COF_E [9] = '{5, 8, 4, 8, 2, 7, 2, 5, 1};

  localparam logic signed [RND_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [RND_W-1:0] OUT_MIN = -64'sh0000_8000_0000_0000;

  typedef enum logic [1:0] {
    GAM_IDLE,
    GAM_LOAD,
    GAM_RUN
  } gam_state_t;

  typedef logic [8:0][F_W-1:0]   f_vec_t;
  typedef logic [8:0][C_W-1:0]   cof_vec_t;
  typedef logic [8:0][MUF_W-1:0] muf_vec_t;
  typedef logic [2:0][PP_W-1:0]  jp_vec_t;
  typedef logic [8:0][P_W-1:0]   p_vec_t;

  typedef struct packed {
    cof_vec_t          c;
    muf_vec_t          muf;
    jp_vec_t           jp;
    logic [PP_W-1:0]   mt_lo;
    logic [PP_W-1:0]   mt_hi;
  } front_t;

  typedef struct packed {
    cof_vec_t          c;
    muf_vec_t          muf;
    logic [W_W-1:0]    mt;
    logic [SQ_W-1:0]   sq;
    logic [E_W-1:0]    e;
  } scale_t;

  // round to nearest, ties up, then drop n fraction bits
  function automatic logic [RND_W-1:0] rnd(input logic [W_W-1:0] x, input int n);
    logic [W_W-1:0] t;
    t = x + (W_W'(1) << (n - 1));
    return RND_W'(t >> n);
  endfunction

  // clamp to the signed 48-bit range
  function automatic logic [P_W-1:0] sat48(input logic [RND_W-1:0] r);
    logic [P_W-1:0] res;
    if ($signed(r) > OUT_MAX) begin
      res = P_W'(OUT_MAX);
    end else if ($signed(r) < OUT_MIN) begin
      res = P_W'(OUT_MIN);
    end else begin
      res = r[P_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/nhs_if.sv @@
// ----------------------------------------------------------------------------
// nhs channel interfaces
// valid/ready channels for gradient input, stress result and configuration
// ----------------------------------------------------------------------------
interface nhs_in_if;
  logic valid;
  logic ready;
  logic signed [nhs_pkg::F_W-1:0] f_r0c0, f_r0c1, f_r0c2;
  logic signed [nhs_pkg::F_W-1:0] f_r1c0, f_r1c1, f_r1c2;
  logic signed [nhs_pkg::F_W-1:0] f_r2c0, f_r2c1, f_r2c2;
  modport source (output valid, f_r0c0, f_r0c1, f_r0c2, f_r1c0, f_r1c1, f_r1c2,
                  f_r2c0, f_r2c1, f_r2c2, input ready);
  modport sink (input valid, f_r0c0, f_r0c1, f_r0c2, f_r1c0, f_r1c1, f_r1c2,
                f_r2c0, f_r2c1, f_r2c2, output ready);
endinterface

interface nhs_out_if;
  logic valid;
  logic ready;
  logic signed [nhs_pkg::P_W-1:0] p_r0c0, p_r0c1, p_r0c2;
  logic signed [nhs_pkg::P_W-1:0] p_r1c0, p_r1c1, p_r1c2;
  logic signed [nhs_pkg::P_W-1:0] p_r2c0, p_r2c1, p_r2c2;
  logic signed [nhs_pkg::P_W-1:0] energy_density;
  modport source (output valid, p_r0c0, p_r0c1, p_r0c2, p_r1c0, p_r1c1, p_r1c2,
                  p_r2c0, p_r2c1, p_r2c2, energy_density, input ready);
  modport sink (input valid, p_r0c0, p_r0c1, p_r0c2, p_r1c0, p_r1c1, p_r1c2,
                p_r2c0, p_r2c1, p_r2c2, energy_density, output ready);
endinterface

interface nhs_cfg_if;
  logic valid;
  logic ready;
  logic [nhs_pkg::IDX_W-1:0] index;
  logic [nhs_pkg::CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/neo_hookean_stress_energy_top.sv @@
// ----------------------------------------------------------------------------
// neo_hookean_stress_energy_top
// stable neo-hookean first piola stress and energy density for 3x3 gradients
// ----------------------------------------------------------------------------
// in_ch takes one deformation gradient per request (nine signed q4.20
// entries); out_ch returns nine signed q32.16 stress entries and the energy
// density, saturated to 48 bits, one result per request, in order.
// cfg_ch writes mu (index 0) and lambda (index 1), unsigned q16.16; other
// indexes are ignored. cfg_ch is always ready.
// nine register stages; one result per cycle sustained while out_ch.ready
// is high and the gamma divider is idle.
// after a register write the gamma divider runs through a start, a load and
// 31 quotient bits; in_ch.ready stays low during that time.
// reset loads mu = lambda = 1.0, summed modulus 2.0, gamma = 1.5 directly and
// empties the pipeline; no clearing pass.
// when out_ch.ready is low, each stage holds its request and stages with a
// free slot keep filling, so in_ch stays ready until all nine are full.
// ----------------------------------------------------------------------------
module neo_hookean_stress_energy_top (
  input logic        clk,
  input logic        rst_n,
  nhs_in_if.sink     in_ch,
  nhs_out_if.source  out_ch,
  nhs_cfg_if.sink    cfg_ch
);

  logic [nhs_pkg::CFG_W-1:0] mu_r, lam_r;
  logic                      start_r;
  logic                      cfg_wr, cfg_known;
  logic [nhs_pkg::LH_W-1:0]  lh;
  logic [nhs_pkg::GAM_W-1:0] gamma;
  logic                      gam_busy;
  logic                      hold_in;

  nhs_pkg::f_vec_t  in_f;
  nhs_pkg::front_t  front_data;
  nhs_pkg::scale_t  scale_data;
  nhs_pkg::p_vec_t  p;
  logic [nhs_pkg::P_W-1:0] energy;
  logic front_rdy, front_vld, scale_rdy, scale_vld, stress_rdy;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign cfg_known    = (cfg_ch.index == nhs_pkg::REG_SHEAR) ||
                        (cfg_ch.index == nhs_pkg::REG_BULK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r    <= nhs_pkg::MU_RST;
      lam_r   <= nhs_pkg::LAM_RST;
      start_r <= 1'b0;
    end else begin
      start_r <= cfg_wr && cfg_known;
      if (cfg_wr && cfg_ch.index == nhs_pkg::REG_SHEAR) mu_r  <= cfg_ch.data;
      if (cfg_wr && cfg_ch.index == nhs_pkg::REG_BULK)  lam_r <= cfg_ch.data;
    end
  end

  nhs_gamma u_gamma (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .mu    (mu_r),
    .lam   (lam_r),
    .lh    (lh),
    .gamma (gamma),
    .busy  (gam_busy)
  );

  // input gating while gamma is recomputed
  assign hold_in     = gam_busy || start_r;
  assign in_ch.ready = front_rdy && !hold_in;

  assign in_f[0] = in_ch.f_r0c0;
  assign in_f[1] = in_ch.f_r0c1;
  assign in_f[2] = in_ch.f_r0c2;
  assign in_f[3] = in_ch.f_r1c0;
  assign in_f[4] = in_ch.f_r1c1;
  assign in_f[5] = in_ch.f_r1c2;
  assign in_f[6] = in_ch.f_r2c0;
  assign in_f[7] = in_ch.f_r2c1;
  assign in_f[8] = in_ch.f_r2c2;

  nhs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid && !hold_in),
    .in_ready  (front_rdy),
    .in_f      (in_f),
    .mu        (mu_r),
    .out_valid (front_vld),
    .out_ready (scale_rdy),
    .out_data  (front_data)
  );

  nhs_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_vld),
    .in_ready  (scale_rdy),
    .in_data   (front_data),
    .lh        (lh),
    .gamma     (gamma),
    .out_valid (scale_vld),
    .out_ready (stress_rdy),
    .out_data  (scale_data)
  );

  nhs_stress u_stress (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (scale_vld),
    .in_ready   (stress_rdy),
    .in_data    (scale_data),
    .lh         (lh),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_p      (p),
    .out_energy (energy)
  );

  // result fields
  assign out_ch.p_r0c0         = p[0];
  assign out_ch.p_r0c1         = p[1];
  assign out_ch.p_r0c2         = p[2];
  assign out_ch.p_r1c0         = p[3];
  assign out_ch.p_r1c1         = p[4];
  assign out_ch.p_r1c2         = p[5];
  assign out_ch.p_r2c0         = p[6];
  assign out_ch.p_r2c1         = p[7];
  assign out_ch.p_r2c2         = p[8];
  assign out_ch.energy_density = energy;

`ifndef SYNTHESIS
  // a known register write blocks new requests in the following cycle
  a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_known |=> !in_ch.ready)
    else $error("request accepted right after a register write");

  // summed modulus follows the registers once the divider is done
  a_lh_match: assert property (@(posedge clk) disable iff (!rst_n)
    !gam_busy && !start_r |-> lh == ({1'b0, mu_r} + {1'b0, lam_r}))
    else $error("summed modulus out of step with registers");

  // gamma stays within one to two
  a_gamma_range: assert property (@(posedge clk) disable iff (!rst_n)
    !gam_busy |-> gamma >= nhs_pkg::GAM_ONE && gamma <= {nhs_pkg::GAM_ONE, 1'b0})
    else $error("gamma out of range");
`endif

endmodule

@@ rtl/core/nhs_gamma.sv @@
// ----------------------------------------------------------------------------
// nhs_gamma
// summed modulus and gamma = 1 + mu/(mu + lambda), restoring divider, one bit a cycle
// ----------------------------------------------------------------------------
module nhs_gamma (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nhs_pkg::CFG_W-1:0]   mu,
  input  logic [nhs_pkg::CFG_W-1:0]   lam,
  output logic [nhs_pkg::LH_W-1:0]    lh,
  output logic [nhs_pkg::GAM_W-1:0]   gamma,
  output logic                        busy
);

  nhs_pkg::gam_state_t state_r, state_nxt;
  logic [nhs_pkg::LH_W-1:0]  lh_r;
  logic [nhs_pkg::GAM_W-1:0] gamma_r;
  logic [nhs_pkg::LH_W-1:0]  rem_r;
  logic [30:0]               num_r;
  logic [30:0]               q_r;
  logic [nhs_pkg::CNT_W-1:0] cnt_r;
  logic [62:0]               num;
  logic [33:0]               rem_sh;
  logic                      qbit;
  logic [30:0]               q_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (start) begin
      state_nxt = nhs_pkg::GAM_LOAD;
    end else begin
      unique case (state_r)
        nhs_pkg::GAM_IDLE: state_nxt = nhs_pkg::GAM_IDLE;
        nhs_pkg::GAM_LOAD: state_nxt = (lh_r == '0) ? nhs_pkg::GAM_IDLE : nhs_pkg::GAM_RUN;
        nhs_pkg::GAM_RUN:  state_nxt = (cnt_r == '0) ? nhs_pkg::GAM_IDLE : nhs_pkg::GAM_RUN;
        default:           state_nxt = nhs_pkg::GAM_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    busy = (state_r != nhs_pkg::GAM_IDLE);
  end

  // rounded dividend and one restoring step
  always_comb begin
    num    = {1'b0, mu, 30'b0} + 63'(lh_r >> 1);
    rem_sh = {rem_r, num_r[30]};
    qbit   = (rem_sh >= 34'(lh_r));
    q_nxt  = {q_r[29:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nhs_pkg::GAM_IDLE;
      lh_r    <= nhs_pkg::LH_RST;
      gamma_r <= nhs_pkg::GAM_RST;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        lh_r <= {1'b0, mu} + {1'b0, lam};
      end
      if (!start && state_r == nhs_pkg::GAM_LOAD && lh_r == '0) begin
        gamma_r <= nhs_pkg::GAM_ONE;
      end
      if (!start && state_r == nhs_pkg::GAM_RUN && cnt_r == '0) begin
        gamma_r <= nhs_pkg::GAM_ONE + 32'(q_nxt);
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (state_r == nhs_pkg::GAM_LOAD) begin
      rem_r <= 33'(num[62:31]);
      num_r <= num[30:0];
      q_r   <= '0;
      cnt_r <= nhs_pkg::DIV_STEPS;
    end else if (state_r == nhs_pkg::GAM_RUN) begin
      rem_r <= qbit ? 33'(rem_sh - 34'(lh_r)) : 33'(rem_sh);
      num_r <= {num_r[29:0], 1'b0};
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign lh    = lh_r;
  assign gamma = gamma_r;

endmodule

@@ rtl/core/nhs_front.sv @@
// ----------------------------------------------------------------------------
// nhs_front
// stages 1-3: entry products, cofactors, trace term, mu*f, determinant terms
// ----------------------------------------------------------------------------
module nhs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nhs_pkg::f_vec_t            in_f,
  input  logic [nhs_pkg::CFG_W-1:0]  mu,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nhs_pkg::front_t            out_data
);

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic [8:0][nhs_pkg::FF_W-1:0] pa_nxt, pb_nxt, sq_nxt;
  logic [8:0][nhs_pkg::FF_W-1:0] pa1_r, pb1_r, sq1_r;
  nhs_pkg::f_vec_t               f1_r, f2_r;
  nhs_pkg::cof_vec_t             c_nxt, c2_r;
  nhs_pkg::muf_vec_t             muf_nxt, muf2_r;
  logic [nhs_pkg::TR_W-1:0]      tr_nxt, tr2_r;
  nhs_pkg::front_t               s3_nxt, s3_r;

  // stage enables
  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // stage 1: products of entries
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pa_nxt[k] = nhs_pkg::FF_W'($signed(in_f[nhs_pkg::COF_A[k]]))
                * nhs_pkg::FF_W'($signed(in_f[nhs_pkg::COF_B[k]]));
      pb_nxt[k] = nhs_pkg::FF_W'($signed(in_f[nhs_pkg::COF_D[k]]))
                * nhs_pkg::FF_W'($signed(in_f[nhs_pkg::COF_E[k]]));
      sq_nxt[k] = nhs_pkg::FF_W'($signed(in_f[k])) * nhs_pkg::FF_W'($signed(in_f[k]));
    end
  end

  // stage 2: cofactors, squared sum minus three, mu*f
  always_comb begin
    tr_nxt = -(nhs_pkg::TR_W'(3) << 40);
    for (int k = 0; k < 9; k++) begin
      c_nxt[k]   = nhs_pkg::C_W'($signed(pa1_r[k])) - nhs_pkg::C_W'($signed(pb1_r[k]));
      muf_nxt[k] = nhs_pkg::MUF_W'($signed({1'b0, mu}))
                 * nhs_pkg::MUF_W'($signed(f1_r[k]));
      tr_nxt     = tr_nxt + nhs_pkg::TR_W'(sq1_r[k]);
    end
  end

  // stage 3: determinant terms, split mu*(sumsq - 3)
  always_comb begin
    s3_nxt.c   = c2_r;
    s3_nxt.muf = muf2_r;
    for (int k = 0; k < 3; k++) begin
      s3_nxt.jp[k] = nhs_pkg::PP_W'($signed(f2_r[k])) * nhs_pkg::PP_W'($signed(c2_r[k]));
    end
    s3_nxt.mt_lo = nhs_pkg::PP_W'($signed({1'b0, mu[15:0]})) * nhs_pkg::PP_W'($signed(tr2_r));
    s3_nxt.mt_hi = nhs_pkg::PP_W'($signed({1'b0, mu[31:16]})) * nhs_pkg::PP_W'($signed(tr2_r));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1) begin
      f1_r  <= in_f;
      pa1_r <= pa_nxt;
      pb1_r <= pb_nxt;
      sq1_r <= sq_nxt;
    end
    if (en2) begin
      f2_r   <= f1_r;
      c2_r   <= c_nxt;
      muf2_r <= muf_nxt;
      tr2_r  <= tr_nxt;
    end
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

@@ rtl/core/nhs_scale.sv @@
// ----------------------------------------------------------------------------
// nhs_scale
// stages 4-6: d = j - gamma, s = (mu + lambda)*d, d squared
// ----------------------------------------------------------------------------
module nhs_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nhs_pkg::front_t            in_data,
  input  logic [nhs_pkg::LH_W-1:0]   lh,
  input  logic [nhs_pkg::GAM_W-1:0]  gamma,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nhs_pkg::scale_t            out_data
);

  logic v4_r, v5_r, v6_r;
  logic en4, en5, en6;

  logic [nhs_pkg::W_W-1:0]  d;
  logic [nhs_pkg::DQ_W-1:0] dq4_r;
  logic [nhs_pkg::W_W-1:0]  mt_nxt, mt4_r, mt5_r;
  nhs_pkg::cof_vec_t        c4_r, c5_r;
  nhs_pkg::muf_vec_t        muf4_r, muf5_r;
  logic [nhs_pkg::PP_W-1:0] lhlo_nxt, lhhi_nxt, ddlo_nxt, ddhi_nxt;
  logic [nhs_pkg::PP_W-1:0] lhlo5_r, lhhi5_r, ddlo5_r, ddhi5_r;
  logic [nhs_pkg::W_W-1:0]  lhdq, dd;
  nhs_pkg::scale_t          s6_r;

  // stage enables
  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign in_ready = en4;

  // stage 4: determinant minus gamma, rounded to q.30
  always_comb begin
    d = nhs_pkg::W_W'($signed(in_data.jp[0])) + nhs_pkg::W_W'($signed(in_data.jp[1]))
      + nhs_pkg::W_W'($signed(in_data.jp[2])) - (nhs_pkg::W_W'(gamma) << 30);
    mt_nxt = (nhs_pkg::W_W'($signed(in_data.mt_hi)) << 16)
           + nhs_pkg::W_W'($signed(in_data.mt_lo));
  end

  // stage 5: split products summed modulus times d and d*d
  always_comb begin
    lhlo_nxt = nhs_pkg::PP_W'($signed({1'b0, lh}))
             * nhs_pkg::PP_W'($signed({1'b0, dq4_r[nhs_pkg::DQ_SPL-1:0]}));
    lhhi_nxt = nhs_pkg::PP_W'($signed({1'b0, lh}))
             * nhs_pkg::PP_W'($signed(dq4_r[nhs_pkg::DQ_W-1:nhs_pkg::DQ_SPL]));
    ddlo_nxt = nhs_pkg::PP_W'($signed({1'b0, dq4_r[nhs_pkg::DQ_SPL-1:0]}))
             * nhs_pkg::PP_W'($signed(dq4_r));
    ddhi_nxt = nhs_pkg::PP_W'($signed(dq4_r[nhs_pkg::DQ_W-1:nhs_pkg::DQ_SPL]))
             * nhs_pkg::PP_W'($signed(dq4_r));
  end

  // stage 6: recombine and round
  always_comb begin
    lhdq = (nhs_pkg::W_W'($signed(lhhi5_r)) << nhs_pkg::DQ_SPL)
         + nhs_pkg::W_W'($signed(lhlo5_r));
    dd   = (nhs_pkg::W_W'($signed(ddhi5_r)) << nhs_pkg::DQ_SPL)
         + nhs_pkg::W_W'($signed(ddlo5_r));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) v4_r <= in_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en4) begin
      dq4_r  <= nhs_pkg::DQ_W'(nhs_pkg::rnd(d, 30));
      mt4_r  <= mt_nxt;
      c4_r   <= in_data.c;
      muf4_r <= in_data.muf;
    end
    if (en5) begin
      lhlo5_r <= lhlo_nxt;
      lhhi5_r <= lhhi_nxt;
      ddlo5_r <= ddlo_nxt;
      ddhi5_r <= ddhi_nxt;
      mt5_r   <= mt4_r;
      c5_r    <= c4_r;
      muf5_r  <= muf4_r;
    end
    if (en6) begin
      s6_r.sq  <= nhs_pkg::SQ_W'(nhs_pkg::rnd(lhdq, 22));
      s6_r.e   <= nhs_pkg::E_W'(nhs_pkg::rnd(dd, 30));
      s6_r.mt  <= mt5_r;
      s6_r.c   <= c5_r;
      s6_r.muf <= muf5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = s6_r;

endmodule

@@ rtl/core/nhs_stress.sv @@
// ----------------------------------------------------------------------------
// nhs_stress
// stages 7-9: s*cof + mu*f, energy sum, rounding and saturation
// ----------------------------------------------------------------------------
module nhs_stress (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nhs_pkg::scale_t            in_data,
  input  logic [nhs_pkg::LH_W-1:0]   lh,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nhs_pkg::p_vec_t            out_p,
  output logic [nhs_pkg::P_W-1:0]    out_energy
);

  logic v7_r, v8_r, v9_r;
  logic en7, en8, en9;

  logic [8:0][nhs_pkg::PP_W-1:0] sclo_nxt, schi_nxt, sclo7_r, schi7_r;
  logic [nhs_pkg::PP_W-1:0]      lelo_nxt, lehi_nxt, lelo7_r, lehi7_r;
  nhs_pkg::muf_vec_t             muf7_r;
  logic [nhs_pkg::W_W-1:0]       mt7_r;
  logic [8:0][nhs_pkg::W_W-1:0]  acc_nxt, acc8_r;
  logic [nhs_pkg::W_W-1:0]       eacc_nxt, eacc8_r;
  nhs_pkg::p_vec_t               p_nxt, p9_r;
  logic [nhs_pkg::P_W-1:0]       en_nxt, energy9_r;

  // stage enables
  assign en9      = !v9_r || out_ready;
  assign en8      = !v8_r || en9;
  assign en7      = !v7_r || en8;
  assign in_ready = en7;

  // stage 7: split products s*cof and summed modulus times d^2
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      sclo_nxt[k] = nhs_pkg::PP_W'($signed({1'b0, in_data.sq[nhs_pkg::SQ_SPL-1:0]}))
                  * nhs_pkg::PP_W'($signed(in_data.c[k]));
      schi_nxt[k] = nhs_pkg::PP_W'($signed(in_data.sq[nhs_pkg::SQ_W-1:nhs_pkg::SQ_SPL]))
                  * nhs_pkg::PP_W'($signed(in_data.c[k]));
    end
    lelo_nxt = nhs_pkg::PP_W'($signed({1'b0, in_data.e[nhs_pkg::E_SPL-1:0]}))
             * nhs_pkg::PP_W'($signed({1'b0, lh}));
    lehi_nxt = nhs_pkg::PP_W'($signed(in_data.e[nhs_pkg::E_W-1:nhs_pkg::E_SPL]))
             * nhs_pkg::PP_W'($signed({1'b0, lh}));
  end

  // stage 8: exact sums in q.64 and q.56
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      acc_nxt[k] = (nhs_pkg::W_W'($signed(schi7_r[k])) << nhs_pkg::SQ_SPL)
                 + nhs_pkg::W_W'($signed(sclo7_r[k]))
                 + (nhs_pkg::W_W'($signed(muf7_r[k])) << 28);
    end
    eacc_nxt = mt7_r + (((nhs_pkg::W_W'($signed(lehi7_r)) << nhs_pkg::E_SPL)
             + nhs_pkg::W_W'($signed(lelo7_r))) << 10);
  end

  // stage 9: round to q.16 and clamp
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      p_nxt[k] = nhs_pkg::sat48(nhs_pkg::rnd(acc8_r[k], 48));
    end
    en_nxt = nhs_pkg::sat48(nhs_pkg::rnd(eacc8_r, 41));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      if (en7) v7_r <= in_valid;
      if (en8) v8_r <= v7_r;
      if (en9) v9_r <= v8_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en7) begin
      sclo7_r <= sclo_nxt;
      schi7_r <= schi_nxt;
      lelo7_r <= lelo_nxt;
      lehi7_r <= lehi_nxt;
      muf7_r  <= in_data.muf;
      mt7_r   <= in_data.mt;
    end
    if (en8) begin
      acc8_r  <= acc_nxt;
      eacc8_r <= eacc_nxt;
    end
    if (en9) begin
      p9_r      <= p_nxt;
      energy9_r <= en_nxt;
    end
  end

  assign out_valid  = v9_r;
  assign out_p      = p9_r;
  assign out_energy = energy9_r;

endmodule
